// ----- src/ip_pair_connection_counter_defines.svh -----
// assertion macros shared by the ip pair connection counter rtl
`ifndef IP_PAIR_CONNECTION_COUNTER_DEFINES_SVH
`define IP_PAIR_CONNECTION_COUNTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ipc_pkg.sv -----
// types, constants and helpers of the ip pair connection counter
`timescale 1ns / 1ps
`default_nettype none

package ipc_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int ENT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int ALARM_CNT_W = 16;
    localparam int CFG_IDX_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RENEW_PERIOD    = CFG_IDX_W'(1);

    localparam logic [15:0] THRESHOLD_RESET = 16'd10;
    localparam logic [31:0] PERIOD_RESET    = 32'd120;

    localparam logic ALARM_TABLE = 1'b0;
    localparam logic ALARM_PAIR  = 1'b1;

    typedef struct packed {
        logic [31:0]            src;
        logic [31:0]            dst;
        logic [COUNT_WIDTH-1:0] cnt;
    } t_entry;

    typedef struct packed {
        logic                   kind;
        logic [31:0]            src;
        logic [31:0]            dst;
        logic [ALARM_CNT_W-1:0] cnt;
    } t_alarm;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOOK  = 4'b0010,
        S_ALARM = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // clamp a pair count to the alarm count field
    function automatic logic [ALARM_CNT_W-1:0] sat_alarm_cnt(
        input logic [COUNT_WIDTH-1:0] c
    );
        logic [31:0] wide;
        wide = 32'(c);
        if (wide > 32'h0000_FFFF) begin
            sat_alarm_cnt = '1;
        end else begin
            sat_alarm_cnt = ALARM_CNT_W'(wide);
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/ipc_cell.sv -----
// one table cell of the rotating pair ring
`timescale 1ns / 1ps
`default_nettype none

module ipc_cell (
    input  wire            i_clk,
    input  wire            i_shift,
    input  ipc_pkg::t_entry i_entry,
    output ipc_pkg::t_entry o_entry
);

    ipc_pkg::t_entry r_entry;

    // takes the neighbor's entry on every ring step
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// ----- src/ip_pair_connection_counter.sv -----
// top level of the ip pair connection counter: renewal timer, ring control, alarms
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+----------------------------------------
//  packet   | in        | start high, busy low     | time_sec, frame_is_ipv4, src/dst addr
//  alarm    | out       | o_alarm_strobe, 1 cycle  | kind, src, dst, count, last_alarm
//  config   | in        | i_cfg_valid & o_cfg_ready| i_cfg_index, i_cfg_data
//
// a non-ipv4 item only updates the timer (a renewal also empties the table) and is done in the accept cycle
// an ipv4 item keeps busy high for one lap of the cell ring for lookup/insert
// and one lap for the alarm scan, one cell passing the head per cycle,
// then for the done state that flushes the last alarm
// each alarm is held until the next one is found or the scan ends,
// then leaves from an output register in the next cycle
// synchronous active-low reset clears timer, entry count and control and reloads the config defaults;
// the table cells hold no reset value, only entries below the count are read
// results cannot be stalled; config is always ready
`timescale 1ns / 1ps
`default_nettype none
`include "ip_pair_connection_counter_defines.svh"

module ip_pair_connection_counter (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // packet item
    input  wire                                 start,
    output logic                                busy,
    input  wire  [31:0]                         i_time_sec,
    input  wire                                 i_frame_is_ipv4,
    input  wire  [31:0]                         i_src_addr,
    input  wire  [31:0]                         i_dst_addr,
    // alarm results
    output logic                                o_alarm_strobe,
    output logic                                o_alarm_kind,
    output logic [31:0]                         o_alarm_src,
    output logic [31:0]                         o_alarm_dst,
    output logic [15:0]                         o_alarm_count,
    output logic                                o_last_alarm,
    // configuration writes
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [ipc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [31:0]                         i_cfg_data
);

    // control and config state
    ipc_pkg::t_state                r_state, n_state;
    logic [ipc_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic [ipc_pkg::ENT_W-1:0]      r_used, n_used;
    logic [31:0]                    r_timer, n_timer;
    logic [31:0]                    r_prev, n_prev;
    logic                           r_found, n_found;
    logic [31:0]                    r_src, n_src;
    logic [31:0]                    r_dst, n_dst;
    logic [15:0]                    r_thr;
    logic [31:0]                    r_period;

    // alarm staging: one pending alarm so the last one can be marked
    logic                           r_pend_vld, n_pend_vld;
    ipc_pkg::t_alarm                r_pend, n_pend;
    logic                           r_out_vld, n_out_vld;
    logic                           r_out_last, n_out_last;
    ipc_pkg::t_alarm                r_out, n_out;

    // ring
    ipc_pkg::t_entry                w_cell [ipc_pkg::TABLE_DEPTH];
    ipc_pkg::t_entry                w_head;
    ipc_pkg::t_entry                w_tail;
    logic                           w_shift;

    logic                           w_accept;
    logic [31:0]                    w_elapsed;
    logic [32:0]                    w_sum;
    logic                           w_in_table;
    logic                           w_match;
    logic                           w_insert;
    logic                           w_hit;
    logic                           w_last_step;

    assign busy        = (r_state != ipc_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_shift     = (r_state == ipc_pkg::S_LOOK) || (r_state == ipc_pkg::S_ALARM);
    assign w_head      = w_cell[0];

    // ring of cells: cell k takes from cell k+1, the last one from the head logic
    for (genvar k = 0; k < ipc_pkg::TABLE_DEPTH; k++) begin : g_cell
        if (k == ipc_pkg::TABLE_DEPTH - 1) begin : g_tail
            ipc_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_entry (w_tail),
                .o_entry (w_cell[k])
            );
        end else begin : g_body
            ipc_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_entry (w_cell[k+1]),
                .o_entry (w_cell[k])
            );
        end
    end

    // renewal timer sum, kept one bit wider so overflow still renews
    assign w_elapsed = i_time_sec - r_prev;
    assign w_sum     = {1'b0, r_timer} + ((r_prev != 32'd0) ? {1'b0, w_elapsed} : 33'd0);

    // head-of-ring tests, position r_idx in table order
    assign w_in_table  = ipc_pkg::ENT_W'(r_idx) < r_used;
    assign w_match     = w_in_table && !r_found
                         && (w_head.src == r_src) && (w_head.dst == r_dst);
    assign w_insert    = (ipc_pkg::ENT_W'(r_idx) == r_used) && !r_found;
    assign w_hit       = w_in_table && (32'(w_head.cnt) > 32'(r_thr));
    assign w_last_step = (r_idx == ipc_pkg::IDX_W'(ipc_pkg::TABLE_DEPTH - 1));

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_used     = r_used;
        n_timer    = r_timer;
        n_prev     = r_prev;
        n_found    = r_found;
        n_src      = r_src;
        n_dst      = r_dst;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        n_out_vld  = 1'b0;
        n_out_last = r_out_last;
        n_out      = r_out;
        w_tail     = w_head;

        case (r_state)
            ipc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_prev = i_time_sec;
                    if (w_sum >= {1'b0, r_period}) begin
                        n_timer = 32'd0;
                        n_used  = '0;
                    end else begin
                        n_timer = w_sum[31:0];
                    end
                    if (i_frame_is_ipv4) begin
                        n_state = ipc_pkg::S_LOOK;
                        n_idx   = '0;
                        n_found = 1'b0;
                        n_src   = i_src_addr;
                        n_dst   = i_dst_addr;
                    end
                end
            end
            ipc_pkg::S_LOOK: begin
                // bump a matching pair as it passes, or append at the first free slot
                if (w_match) begin
                    n_found = 1'b1;
                    if (w_head.cnt != '1) begin
                        w_tail.cnt = w_head.cnt + ipc_pkg::COUNT_WIDTH'(1);
                    end
                end else if (w_insert) begin
                    n_found    = 1'b1;
                    w_tail.src = r_src;
                    w_tail.dst = r_dst;
                    w_tail.cnt = ipc_pkg::COUNT_WIDTH'(1);
                    n_used     = r_used + ipc_pkg::ENT_W'(1);
                end
                n_idx = r_idx + ipc_pkg::IDX_W'(1);
                if (w_last_step) begin
                    n_state    = ipc_pkg::S_ALARM;
                    n_idx      = '0;
                    n_pend_vld = 32'(n_used) > 32'(r_thr);
                    n_pend     = '{kind: ipc_pkg::ALARM_TABLE, src: 32'd0, dst: 32'd0,
                                   cnt: ipc_pkg::ALARM_CNT_W'(n_used)};
                end
            end
            ipc_pkg::S_ALARM: begin
                // a new hit releases the held alarm, which is then not the last
                if (w_hit) begin
                    if (r_pend_vld) begin
                        n_out_vld  = 1'b1;
                        n_out      = r_pend;
                        n_out_last = 1'b0;
                    end
                    n_pend_vld = 1'b1;
                    n_pend     = '{kind: ipc_pkg::ALARM_PAIR, src: w_head.src,
                                   dst: w_head.dst,
                                   cnt: ipc_pkg::sat_alarm_cnt(w_head.cnt)};
                end
                n_idx = r_idx + ipc_pkg::IDX_W'(1);
                if (w_last_step) begin
                    n_state = ipc_pkg::S_DONE;
                    n_idx   = '0;
                end
            end
            ipc_pkg::S_DONE: begin
                n_out_vld  = r_pend_vld;
                n_out      = r_pend;
                n_out_last = 1'b1;
                n_pend_vld = 1'b0;
                n_state    = ipc_pkg::S_IDLE;
            end
            default: begin
                n_state    = ipc_pkg::S_IDLE;
                n_pend_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ipc_pkg::S_IDLE;
            r_idx      <= '0;
            r_used     <= '0;
            r_timer    <= 32'd0;
            r_prev     <= 32'd0;
            r_found    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_thr      <= ipc_pkg::THRESHOLD_RESET;
            r_period   <= ipc_pkg::PERIOD_RESET;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_used     <= n_used;
            r_timer    <= n_timer;
            r_prev     <= n_prev;
            r_found    <= n_found;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ipc_pkg::CFG_ALARM_THRESHOLD: r_thr    <= i_cfg_data[15:0];
                    ipc_pkg::CFG_RENEW_PERIOD:    r_period <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_alarm_strobe = r_out_vld;
    assign o_alarm_kind   = r_out.kind;
    assign o_alarm_src    = r_out.src;
    assign o_alarm_dst    = r_out.dst;
    assign o_alarm_count  = r_out.cnt;
    assign o_last_alarm   = r_out_last;

    `IPC_ASSERT_IMPL(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= ipc_pkg::ENT_W'(ipc_pkg::TABLE_DEPTH), "entry count beyond table depth")
    `IPC_ASSERT_NEXT(a_ipv4_scans, i_clk, i_rst_n, w_accept && i_frame_is_ipv4, r_state == ipc_pkg::S_LOOK, "ipv4 item did not start lookup lap")
    `IPC_ASSERT_IMPL(a_last_drains, i_clk, i_rst_n, o_alarm_strobe && o_last_alarm, !r_pend_vld, "alarm still held after last alarm")
    `IPC_ASSERT_IMPL(a_pend_phase, i_clk, i_rst_n, r_pend_vld, (r_state == ipc_pkg::S_ALARM) || (r_state == ipc_pkg::S_DONE), "held alarm outside alarm scan")

endmodule

`default_nettype wire
